// ===== hdl/rc4_stream_cipher_unit_macros.svh =====
// Assertion helpers used by the cipher controller (rc4_ctrl).
`ifndef RC4_STREAM_CIPHER_UNIT_MACROS_SVH
`define RC4_STREAM_CIPHER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RC4_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RC4_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rc4_pkg.sv =====
`default_nettype none

package rc4_pkg;

  // Permutation geometry.
  localparam int PERM_AW = 8;

  // Request kinds carried in req_type.
  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  // Controller states: one data path and the key schedule.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_KA,
    ST_KB,
    ST_KC,
    ST_KD
  } state_t;

  // Access to the permutation memory for one cycle.
  typedef struct packed {
    logic               clear;
    logic               we;
    logic [PERM_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [PERM_AW-1:0] raddr;
  } perm_req_t;

endpackage

`default_nettype wire

// ===== hdl/rc4_req_if.sv =====
`default_nettype none

// Input channel: key bytes and data bytes.
interface rc4_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] byte_value;
  logic       last_of_buffer;

  modport source (output valid, output req_type, output byte_value,
                  output last_of_buffer, input ready);
  modport sink (input valid, input req_type, input byte_value,
                input last_of_buffer, output ready);
endinterface

`default_nettype wire

// ===== hdl/rc4_rsp_if.sv =====
`default_nettype none

// Output channel: processed data bytes.
interface rc4_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/rc4_stream_cipher_unit.sv =====
// RC4 stream cipher. Key bytes (req_type 0) are stored in order and give no
// result. The key byte that brings the count up to the key length
// (key_length clamped to 1..KEY_DEPTH) starts the key schedule, which resets
// the permutation to identity and clears both indices; the schedule runs one
// step per permutation entry (read S[n] and the key byte, read S[acc], then
// two writes through the single write port of the permutation memory), and
// no transaction is accepted meanwhile. A data byte (req_type 1) makes the
// dependent reads of S[i], S[j] and S[t] and the two swap writes in one
// memory before the next byte is accepted; its result, with last_of_buffer
// copied to out_last, waits in an output register, so a new byte is accepted
// while the result is pending. The user must write key_length through
// cfg_wr_en and cfg_wr_data only while idle; the block does not enforce it.
`default_nettype none

module rc4_stream_cipher_unit #(
  parameter int KEY_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  rc4_req_if.sink         req,
  rc4_rsp_if.source       rsp,
  input  wire logic       cfg_wr_en,
  input  wire logic [8:0] cfg_wr_data
);

  localparam int         KAW       = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam logic [8:0] KeyDepthW = 9'(KEY_DEPTH);

  logic [8:0]                  key_length;
  logic [8:0]                  eff_len;
  rc4_pkg::perm_req_t          perm;
  logic [rc4_pkg::PERM_AW-1:0] perm_rdata;
  logic                        key_we;
  logic [KAW-1:0]              key_waddr;
  logic [7:0]                  key_wdata;
  logic [KAW-1:0]              key_raddr;
  logic [7:0]                  key_rdata;

  // Key length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= 9'd16;
    end else if (cfg_wr_en) begin
      key_length <= cfg_wr_data;
    end
  end

  // Clamp the key length into the usable range.
  always_comb begin
    if (key_length == 9'd0) begin
      eff_len = 9'd1;
    end else if (key_length > KeyDepthW) begin
      eff_len = KeyDepthW;
    end else begin
      eff_len = key_length;
    end
  end

  rc4_ctrl #(
    .KEY_DEPTH (KEY_DEPTH),
    .KAW       (KAW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .eff_len    (eff_len),
    .req        (req),
    .rsp        (rsp),
    .perm       (perm),
    .perm_rdata (perm_rdata),
    .key_we     (key_we),
    .key_waddr  (key_waddr),
    .key_wdata  (key_wdata),
    .key_raddr  (key_raddr),
    .key_rdata  (key_rdata)
  );

  rc4_perm_mem u_perm_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (perm),
    .rdata (perm_rdata)
  );

  rc4_key_mem #(
    .KEY_DEPTH (KEY_DEPTH),
    .KAW       (KAW)
  ) u_key_mem (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

endmodule

`default_nettype wire

// ===== hdl/rc4_perm_mem.sv =====
`default_nettype none

// Permutation memory, 256 x 8, one write and one registered read per cycle.
// Each entry has a valid bit; an entry that is not valid reads as its own
// address, which gives the identity permutation after reset or a clear.
module rc4_perm_mem (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire rc4_pkg::perm_req_t        req,
  output logic [rc4_pkg::PERM_AW-1:0]    rdata
);

  localparam int Depth = 2 ** rc4_pkg::PERM_AW;

  logic [7:0]                   mem [Depth];
  logic [Depth-1:0]             valid;
  logic [7:0]                   rdata_q;
  logic [rc4_pkg::PERM_AW-1:0]  raddr_q;
  logic                         rvalid_q;

  // Storage array with registered read; a read at the written address
  // returns the old contents.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_q  <= mem[req.raddr];
    raddr_q  <= req.raddr;
    rvalid_q <= valid[req.raddr];
  end

  // Valid bits are cleared together on reset and on a schedule start.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.clear) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.waddr] <= 1'b1;
    end
  end

  assign rdata = rvalid_q ? rdata_q : raddr_q;

endmodule

`default_nettype wire

// ===== hdl/rc4_key_mem.sv =====
`default_nettype none

// Key store with one write port and a registered read port.
module rc4_key_mem #(
  parameter int KEY_DEPTH = 256,
  parameter int KAW       = 8
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [KAW-1:0] waddr,
  input  wire logic [7:0]     wdata,
  input  wire logic [KAW-1:0] raddr,
  output logic [7:0]          rdata
);

  logic [7:0] mem [KEY_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/rc4_ctrl.sv =====
`default_nettype none

`include "rc4_stream_cipher_unit_macros.svh"

// Sequencer for key loading, the key schedule and the per-byte keystream.
module rc4_ctrl #(
  parameter int KEY_DEPTH = 256,
  parameter int KAW       = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [8:0]         eff_len,
  rc4_req_if.sink                 req,
  rc4_rsp_if.source               rsp,
  output rc4_pkg::perm_req_t      perm,
  input  wire logic [7:0]         perm_rdata,
  output logic                    key_we,
  output logic [KAW-1:0]          key_waddr,
  output logic [7:0]              key_wdata,
  output logic [KAW-1:0]          key_raddr,
  input  wire logic [7:0]         key_rdata
);

  localparam logic [8:0] KeyDepthW = 9'(KEY_DEPTH);

  rc4_pkg::state_t state;
  rc4_pkg::state_t state_next;

  logic [7:0]     idx_i;
  logic [7:0]     idx_j;
  logic [8:0]     kcnt;
  logic [8:0]     sched_len;
  logic [7:0]     n;
  logic [KAW-1:0] k;
  logic [7:0]     acc;
  logic [7:0]     s_a;
  logic [7:0]     s_b;
  logic [7:0]     i1;
  logic [7:0]     j1;
  logic [7:0]     t;
  logic [7:0]     data_byte;
  logic           data_last;
  logic           rsp_valid;
  logic           rsp_valid_next;
  logic [7:0]     out_byte;
  logic           out_last;

  logic           accept;
  logic           is_key;
  logic [8:0]     kcnt_inc;
  logic           start_sched;
  logic [8:0]     k_inc;
  logic [7:0]     ks;
  logic           out_load;

  // Input transaction and key counting.
  assign accept      = req.valid && req.ready;
  assign is_key      = (req.req_type == rc4_pkg::REQ_KEY);
  assign kcnt_inc    = kcnt + 9'd1;
  assign start_sched = accept && is_key && (kcnt_inc >= eff_len);
  assign k_inc       = 9'(k) + 9'd1;

  // Keystream byte, forwarding the swap values when S[t] was just written
  // or is still to be written.
  always_comb begin
    if (t == j1) begin
      ks = s_a;
    end else if (t == i1) begin
      ks = s_b;
    end else begin
      ks = perm_rdata;
    end
  end

  // Key store write on a key transaction, read at the schedule key index.
  assign key_we    = accept && is_key && (kcnt < KeyDepthW);
  assign key_waddr = kcnt[KAW-1:0];
  assign key_wdata = req.byte_value;
  assign key_raddr = k;

  // Next state, memory access and handshake.
  always_comb begin
    state_next  = state;
    req.ready   = 1'b0;
    out_load    = 1'b0;
    perm.clear  = 1'b0;
    perm.we     = 1'b0;
    perm.waddr  = i1;
    perm.wdata  = perm_rdata;
    perm.raddr  = idx_i + 8'd1;
    unique case (state)
      rc4_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (accept) begin
          if (!is_key) begin
            state_next = rc4_pkg::ST_D1;
          end else if (start_sched) begin
            perm.clear = 1'b1;
            state_next = rc4_pkg::ST_KA;
          end
        end
      end
      rc4_pkg::ST_D1: begin
        perm.raddr = idx_j + perm_rdata;
        state_next = rc4_pkg::ST_D2;
      end
      rc4_pkg::ST_D2: begin
        perm.we    = 1'b1;
        perm.waddr = i1;
        perm.wdata = perm_rdata;
        perm.raddr = s_a + perm_rdata;
        state_next = rc4_pkg::ST_D3;
      end
      rc4_pkg::ST_D3: begin
        perm.we    = 1'b1;
        perm.waddr = j1;
        perm.wdata = s_a;
        perm.raddr = t;
        if (!rsp_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = rc4_pkg::ST_IDLE;
        end
      end
      rc4_pkg::ST_KA: begin
        perm.raddr = n;
        state_next = rc4_pkg::ST_KB;
      end
      rc4_pkg::ST_KB: begin
        perm.raddr = acc + key_rdata + perm_rdata;
        state_next = rc4_pkg::ST_KC;
      end
      rc4_pkg::ST_KC: begin
        perm.we    = 1'b1;
        perm.waddr = n;
        perm.wdata = perm_rdata;
        perm.raddr = acc;
        state_next = rc4_pkg::ST_KD;
      end
      rc4_pkg::ST_KD: begin
        perm.we    = 1'b1;
        perm.waddr = acc;
        perm.wdata = s_a;
        perm.raddr = acc;
        state_next = (n == 8'hFF) ? rc4_pkg::ST_IDLE : rc4_pkg::ST_KA;
      end
      default: begin
        state_next = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rc4_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Cipher indices and key count.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_i <= '0;
      idx_j <= '0;
      kcnt  <= '0;
    end else if (start_sched) begin
      idx_i <= '0;
      idx_j <= '0;
      kcnt  <= '0;
    end else if (accept && is_key) begin
      kcnt <= kcnt_inc;
    end else if (out_load) begin
      idx_i <= i1;
      idx_j <= j1;
    end
  end

  // Working registers of the data path and the key schedule.
  always_ff @(posedge clk) begin
    if (state == rc4_pkg::ST_IDLE && accept) begin
      data_byte <= req.byte_value;
      data_last <= req.last_of_buffer;
      i1        <= idx_i + 8'd1;
    end
    if (start_sched) begin
      sched_len <= eff_len;
      n         <= '0;
      k         <= '0;
      acc       <= '0;
    end
    unique case (state)
      rc4_pkg::ST_D1: begin
        s_a <= perm_rdata;
        j1  <= idx_j + perm_rdata;
      end
      rc4_pkg::ST_D2: begin
        s_b <= perm_rdata;
        t   <= s_a + perm_rdata;
      end
      rc4_pkg::ST_KB: begin
        s_a <= perm_rdata;
        acc <= acc + key_rdata + perm_rdata;
      end
      rc4_pkg::ST_KD: begin
        n <= n + 8'd1;
        if (k_inc >= sched_len) begin
          k <= '0;
        end else begin
          k <= k_inc[KAW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: holds one result until the sink takes it.
  always_comb begin
    if (out_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= data_byte ^ ks;
      out_last <= data_last;
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.out_byte = out_byte;
  assign rsp.out_last = out_last;

  // Checks on the sequencing.
  `RC4_ASSERT_NEXT(a_data_starts, clk, rst, accept && !is_key,
    state == rc4_pkg::ST_D1, "data transaction did not start the data path")
  `RC4_ASSERT_NEXT(a_sched_ends, clk, rst, state == rc4_pkg::ST_KD && n == 8'hFF,
    state == rc4_pkg::ST_IDLE && kcnt == 9'd0, "key schedule did not end cleanly")
  `RC4_ASSERT_SAME(a_perm_write, clk, rst, perm.we,
    state == rc4_pkg::ST_D2 || state == rc4_pkg::ST_D3 ||
    state == rc4_pkg::ST_KC || state == rc4_pkg::ST_KD,
    "permutation written outside a write step")
  `RC4_ASSERT_SAME(a_sched_idx, clk, rst, state == rc4_pkg::ST_KA && n == 8'd0,
    idx_i == 8'd0 && idx_j == 8'd0, "indices not cleared at schedule start")

endmodule

`default_nettype wire
